>>> design/b64ld_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and the character classifier of the base64 line decoder.
// No dependencies; all files of the block but the RAM refer to it by scoped names.
package b64ld_pkg;

    localparam int unsigned CMD_ADDR_W  = 8;
    localparam int unsigned CMD_CNT_W   = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [1:0] REQ_RESET  = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_LAST  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CLS_BLANK     = 8'hE0;
    localparam logic [7:0] CLS_LF        = 8'hF0;
    localparam logic [7:0] CLS_CR        = 8'hF1;
    localparam logic [7:0] CLS_END       = 8'hF2;
    localparam logic [7:0] CLS_BAD       = 8'hFF;
    localparam logic [7:0] CLS_SKIP_MASK = 8'h13;
    localparam logic [7:0] CLS_SKIP_CODE = 8'hF3;
    localparam logic [7:0] CHAR_PAD      = 8'h3D;

    localparam int unsigned LAST_LEN_RESET = 30;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       end_of_chunk;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic                  wr_en;
        logic [CMD_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic                  dec_en;
        logic [CMD_CNT_W-1:0]  dec_bytes;
        logic                  st_en;
        logic [1:0]            st_val;
    } t_cmd;

    function automatic logic [7:0] classify(input logic [7:0] b);
        logic [7:0] c;
        c = {1'b0, b[6:0]};
        if (c >= 8'h41 && c <= 8'h5A) begin
            classify = c - 8'd65;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            classify = c - 8'd71;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            classify = c + 8'd4;
        end else if (c == 8'h2B) begin
            classify = 8'd62;
        end else if (c == 8'h2F) begin
            classify = 8'd63;
        end else if (c == CHAR_PAD) begin
            classify = 8'd0;
        end else if (c == 8'h09 || c == 8'h20) begin
            classify = CLS_BLANK;
        end else if (c == 8'h0A) begin
            classify = CLS_LF;
        end else if (c == 8'h0D) begin
            classify = CLS_CR;
        end else if (c == 8'h2D) begin
            classify = CLS_END;
        end else begin
            classify = CLS_BAD;
        end
    endfunction

    function automatic logic is_skipped(input logic [7:0] cls);
        is_skipped = ((cls | CLS_SKIP_MASK) == CLS_SKIP_CODE);
    endfunction

endpackage

>>> design/b64ld_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module b64ld_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/b64ld_queue.sv
`timescale 1ns / 1ps
// Short command queue between the classifying front end and the decoding back end.
// Depends on b64ld_pkg for the command type and the queue depth.
module b64ld_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64ld_pkg::t_cmd   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output b64ld_pkg::t_cmd   o_data,
    output logic              o_empty
);

    localparam int unsigned PTR_W = $clog2(b64ld_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(b64ld_pkg::QUEUE_DEPTH + 1);

    b64ld_pkg::t_cmd  r_mem [b64ld_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(b64ld_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(b64ld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(b64ld_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("Command pushed into a full queue.");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Command popped from an empty queue.");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(b64ld_pkg::QUEUE_DEPTH))
        else $error("Queue fill count out of range.");

endmodule

>>> design/b64ld_front.sv
`timescale 1ns / 1ps
// Front end: accepts request transfers, classifies characters, keeps the line and call
// context and issues store, decode and status commands. Depends on b64ld_pkg.
module b64ld_front #(
    parameter int unsigned LINE_CHARS   = 64,
    parameter int unsigned MAX_LINE_LEN = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  b64ld_pkg::t_in_item   i_in_item,
    output logic                  o_push,
    output b64ld_pkg::t_cmd       o_cmd,
    input  logic                  i_full
);

    localparam int unsigned CNT_W  = $clog2(LINE_CHARS + 1);
    localparam int unsigned LEN_W  = $clog2(MAX_LINE_LEN + 1);
    localparam int unsigned ADDR_W = $clog2(LINE_CHARS);
    localparam int unsigned R_MAX  = LINE_CHARS / 4 * 3;
    localparam int unsigned R_W0   = $clog2(R_MAX + 1);
    localparam int unsigned R_W1   = $clog2(b64ld_pkg::LAST_LEN_RESET + 1);
    localparam int unsigned R_W    = (R_W0 > R_W1) ? R_W0 : R_W1;
    localparam int unsigned CMP_W  = ((CNT_W > R_W) ? CNT_W : R_W) + 1;

    logic [CNT_W-1:0] r_char_count, n_char_count;
    logic [LEN_W-1:0] r_line_length, n_line_length;
    logic             r_expect_nl, n_expect_nl;
    logic [R_W-1:0]   r_last_len, n_last_len;
    logic             r_pad_seen, n_pad_seen;
    logic [CNT_W-1:0] r_pad_count, n_pad_count;
    logic             r_call_done, n_call_done;
    logic [1:0]       r_call_status, n_call_status;
    logic             r_chunk_open, n_chunk_open;
    logic             r_bad, n_bad;
    logic             r_eq1, n_eq1;
    logic             r_eq2, n_eq2;

    logic             accept;
    logic [7:0]       cls;
    logic             skip_rest;
    logic             endf;
    logic             stop;
    logic [R_W-1:0]   blk_r;
    logic [CNT_W-1:0] quads;

    assign o_in_ready = !i_full;

    always_comb begin
        n_char_count  = r_char_count;
        n_line_length = r_line_length;
        n_expect_nl   = r_expect_nl;
        n_last_len    = r_last_len;
        n_pad_seen    = r_pad_seen;
        n_pad_count   = r_pad_count;
        n_call_done   = r_call_done;
        n_call_status = r_call_status;
        n_chunk_open  = r_chunk_open;
        n_bad         = r_bad;
        n_eq1         = r_eq1;
        n_eq2         = r_eq2;
        o_cmd         = '0;
        cls           = b64ld_pkg::classify(i_in_item.data_byte);
        skip_rest     = 1'b0;
        endf          = 1'b0;
        stop          = 1'b0;
        blk_r         = '0;
        quads         = '0;
        accept        = i_in_valid && !i_full;

        if (accept) begin
            case (i_in_item.req_type)
                b64ld_pkg::REQ_RESET: begin
                    n_char_count  = '0;
                    n_line_length = '0;
                    n_expect_nl   = 1'b0;
                    n_last_len    = R_W'(b64ld_pkg::LAST_LEN_RESET);
                    n_pad_seen    = 1'b0;
                    n_pad_count   = '0;
                    n_call_done   = 1'b0;
                    n_call_status = b64ld_pkg::ST_MORE;
                    n_chunk_open  = 1'b0;
                    n_bad         = 1'b0;
                    n_eq1         = 1'b0;
                    n_eq2         = 1'b0;
                end
                b64ld_pkg::REQ_FINISH: begin
                    n_chunk_open  = 1'b0;
                    n_call_done   = 1'b0;
                    n_call_status = b64ld_pkg::ST_MORE;
                    n_pad_seen    = 1'b0;
                    n_pad_count   = '0;
                    o_cmd.st_en   = 1'b1;
                    o_cmd.st_val  = b64ld_pkg::ST_MORE;
                    if (r_char_count != '0) begin
                        if (r_char_count[1:0] != 2'b00 || r_bad) begin
                            o_cmd.st_val = b64ld_pkg::ST_ERROR;
                        end else begin
                            quads           = r_char_count >> 2;
                            blk_r           = R_W'(CMP_W'(quads) + (CMP_W'(quads) << 1));
                            o_cmd.dec_en    = 1'b1;
                            o_cmd.dec_bytes = b64ld_pkg::CMD_CNT_W'(blk_r);
                            n_char_count    = '0;
                            n_bad           = 1'b0;
                            n_eq1           = 1'b0;
                            n_eq2           = 1'b0;
                        end
                    end
                end
                b64ld_pkg::REQ_DATA: begin
                    if (!r_chunk_open) begin
                        n_chunk_open  = 1'b1;
                        n_call_done   = 1'b0;
                        n_call_status = b64ld_pkg::ST_MORE;
                        n_pad_seen    = 1'b0;
                        n_pad_count   = '0;
                        if (r_char_count == '0 && cls == b64ld_pkg::CLS_END) begin
                            n_call_done   = 1'b1;
                            n_call_status = b64ld_pkg::ST_LAST;
                        end
                    end
                    if (!n_call_done) begin
                        if (r_line_length >= LEN_W'(MAX_LINE_LEN)) begin
                            n_call_done   = 1'b1;
                            n_call_status = b64ld_pkg::ST_ERROR;
                        end else begin
                            if (!b64ld_pkg::is_skipped(cls)) begin
                                o_cmd.wr_en   = 1'b1;
                                o_cmd.wr_addr = b64ld_pkg::CMD_ADDR_W'(r_char_count[ADDR_W-1:0]);
                                o_cmd.wr_data = i_in_item.data_byte;
                                n_char_count  = r_char_count + CNT_W'(1);
                                n_eq2         = r_eq1;
                                n_eq1         = (i_in_item.data_byte == b64ld_pkg::CHAR_PAD);
                                n_bad         = r_bad || (cls == b64ld_pkg::CLS_BAD);
                                n_line_length = r_line_length + LEN_W'(1);
                            end
                            if (i_in_item.data_byte == b64ld_pkg::CHAR_PAD) begin
                                n_pad_seen  = 1'b1;
                                n_pad_count = n_pad_count + CNT_W'(1);
                            end
                            if (cls == b64ld_pkg::CLS_CR) begin
                                n_line_length = '0;
                                skip_rest     = r_expect_nl;
                            end
                            if (cls == b64ld_pkg::CLS_LF) begin
                                n_line_length = '0;
                                if (r_expect_nl) begin
                                    n_expect_nl = 1'b0;
                                    skip_rest   = 1'b1;
                                end
                            end
                            if (!skip_rest) begin
                                n_expect_nl = 1'b0;
                                endf        = (cls == b64ld_pkg::CLS_END);
                                if (i_in_item.end_of_chunk
                                    && (n_char_count[1:0] == 2'b00 || n_pad_count != '0)) begin
                                    endf        = 1'b1;
                                    n_pad_count = CNT_W'(n_eq1) + CNT_W'(n_eq2);
                                end
                                if ((endf && n_char_count[1:0] == 2'b00)
                                    || n_char_count >= CNT_W'(LINE_CHARS)) begin
                                    if (!endf) begin
                                        n_expect_nl = 1'b1;
                                    end
                                    if (n_char_count != '0) begin
                                        quads = n_char_count >> 2;
                                        blk_r = R_W'(CMP_W'(quads) + (CMP_W'(quads) << 1));
                                        if (n_char_count[1:0] != 2'b00 || n_bad) begin
                                            stop          = 1'b1;
                                            n_call_done   = 1'b1;
                                            n_call_status = b64ld_pkg::ST_LAST;
                                        end else if (CMP_W'(n_pad_count) > CMP_W'(blk_r)) begin
                                            stop          = 1'b1;
                                            n_call_done   = 1'b1;
                                            n_call_status = b64ld_pkg::ST_ERROR;
                                        end else if (CMP_W'(n_pad_count) != CMP_W'(blk_r)) begin
                                            o_cmd.dec_en    = 1'b1;
                                            o_cmd.dec_bytes = b64ld_pkg::CMD_CNT_W'(
                                                blk_r - R_W'(n_pad_count));
                                        end
                                        n_char_count = '0;
                                        n_bad        = 1'b0;
                                        n_eq1        = 1'b0;
                                        n_eq2        = 1'b0;
                                    end else begin
                                        n_pad_count = CNT_W'(1);
                                    end
                                    if (!stop) begin
                                        if (blk_r < r_last_len && n_pad_count != '0) begin
                                            n_call_done   = 1'b1;
                                            n_call_status = b64ld_pkg::ST_LAST;
                                        end else begin
                                            n_last_len = blk_r;
                                            if (n_pad_seen) begin
                                                n_call_done   = 1'b1;
                                                n_call_status = b64ld_pkg::ST_LAST;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                    end
                    if (i_in_item.end_of_chunk) begin
                        o_cmd.st_en   = 1'b1;
                        o_cmd.st_val  = n_call_done ? n_call_status : b64ld_pkg::ST_MORE;
                        n_chunk_open  = 1'b0;
                        n_call_done   = 1'b0;
                        n_call_status = b64ld_pkg::ST_MORE;
                        n_pad_seen    = 1'b0;
                        n_pad_count   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
        o_push = accept && (o_cmd.wr_en || o_cmd.dec_en || o_cmd.st_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count  <= '0;
            r_line_length <= '0;
            r_expect_nl   <= 1'b0;
            r_last_len    <= R_W'(b64ld_pkg::LAST_LEN_RESET);
            r_pad_seen    <= 1'b0;
            r_pad_count   <= '0;
            r_call_done   <= 1'b0;
            r_call_status <= b64ld_pkg::ST_MORE;
            r_chunk_open  <= 1'b0;
            r_bad         <= 1'b0;
            r_eq1         <= 1'b0;
            r_eq2         <= 1'b0;
        end else begin
            r_char_count  <= n_char_count;
            r_line_length <= n_line_length;
            r_expect_nl   <= n_expect_nl;
            r_last_len    <= n_last_len;
            r_pad_seen    <= n_pad_seen;
            r_pad_count   <= n_pad_count;
            r_call_done   <= n_call_done;
            r_call_status <= n_call_status;
            r_chunk_open  <= n_chunk_open;
            r_bad         <= n_bad;
            r_eq1         <= n_eq1;
            r_eq2         <= n_eq2;
        end
    end

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_count < CNT_W'(LINE_CHARS))
        else $error("Line store fill count reached the line length without a flush.");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("Command issued while the queue is full.");
    a_decode_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.dec_en) |-> (o_cmd.dec_bytes != '0))
        else $error("Decode command with no bytes to emit.");

endmodule

>>> design/b64ld_back.sv
`timescale 1ns / 1ps
// Back end: owns the line store, writes characters, decodes stored quads to bytes and
// drives the registered result output. Depends on b64ld_pkg and b64ld_ram.
module b64ld_back #(
    parameter int unsigned LINE_CHARS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  b64ld_pkg::t_cmd       i_cmd,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b64ld_pkg::t_out_item  o_out_item
);

    localparam int unsigned ADDR_W = $clog2(LINE_CHARS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_STAT
    } t_state;

    t_state                         r_state, n_state;
    logic [2:0]                     r_ph, n_ph;
    logic [ADDR_W-1:0]              r_base, n_base;
    logic [23:0]                    r_acc, n_acc;
    logic [1:0]                     r_j, n_j;
    logic [b64ld_pkg::CMD_CNT_W-1:0] r_remain, n_remain;
    logic                           r_st_en, n_st_en;
    logic [1:0]                     r_st_val, n_st_val;
    logic                           r_out_valid, n_out_valid;
    b64ld_pkg::t_out_item           r_out_item, n_out_item;

    logic                           out_free;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [7:0]                     rd_data;
    logic [7:0]                     rd_cls;
    logic [7:0]                     emit_byte;

    b64ld_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CHARS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (o_pop && i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr[ADDR_W-1:0]),
        .i_wr_data (i_cmd.wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign rd_addr  = r_base + ADDR_W'(r_ph[1:0]);
    assign rd_cls   = b64ld_pkg::classify(rd_data);

    always_comb begin
        case (r_j)
            2'd0:    emit_byte = r_acc[23:16];
            2'd1:    emit_byte = r_acc[15:8];
            default: emit_byte = r_acc[7:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_base      = r_base;
        n_acc       = r_acc;
        n_j         = r_j;
        n_remain    = r_remain;
        n_st_en     = r_st_en;
        n_st_val    = r_st_val;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_st_en  = i_cmd.st_en;
                    n_st_val = i_cmd.st_val;
                    n_remain = i_cmd.dec_bytes;
                    n_base   = '0;
                    n_ph     = '0;
                    n_j      = '0;
                    if (i_cmd.dec_en) begin
                        n_state = S_READ;
                    end else if (i_cmd.st_en) begin
                        n_state = S_STAT;
                    end
                end
            end
            S_READ: begin
                rd_en = (r_ph != 3'd4);
                if (r_ph != 3'd0) begin
                    n_acc = {r_acc[17:0], rd_cls[5:0]};
                end
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) begin
                    n_state = S_EMIT;
                    n_j     = '0;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_byte = emit_byte;
                    n_out_item.kind     = b64ld_pkg::KIND_DATA;
                    n_out_item.status   = b64ld_pkg::ST_MORE;
                    n_out_item.last     = (r_remain == b64ld_pkg::CMD_CNT_W'(1)) && !r_st_en;
                    n_remain            = r_remain - b64ld_pkg::CMD_CNT_W'(1);
                    if (r_remain == b64ld_pkg::CMD_CNT_W'(1)) begin
                        n_state = r_st_en ? S_STAT : S_IDLE;
                    end else if (r_j == 2'd2) begin
                        n_base  = r_base + ADDR_W'(4);
                        n_ph    = '0;
                        n_state = S_READ;
                    end else begin
                        n_j = r_j + 2'd1;
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_item.out_byte = 8'd0;
                    n_out_item.kind     = b64ld_pkg::KIND_STATUS;
                    n_out_item.status   = r_st_val;
                    n_out_item.last     = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ph       <= n_ph;
        r_base     <= n_base;
        r_acc      <= n_acc;
        r_j        <= n_j;
        r_remain   <= n_remain;
        r_st_en    <= n_st_en;
        r_st_val   <= n_st_val;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_remain != '0))
        else $error("Byte emission with no bytes left to emit.");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.kind == b64ld_pkg::KIND_STATUS) |-> r_out_item.last)
        else $error("Status result not marked as the final result.");
    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_ph <= 3'd4))
        else $error("Quad read phase out of range.");

endmodule

>>> design/base64_line_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the streaming base64 line decoder: front end, command queue and back end.
// Depends on b64ld_pkg, b64ld_front, b64ld_queue and b64ld_back.

// A request transfer is taken whenever the four-entry command queue has room, so the input
// keeps flowing while decoded bytes are still draining. The back end pops one command at a
// time while idle, and popping a store command writes its character into the line store. A
// line flush then reads the four characters of each group one after another through the
// single read port of the line store. It emits up to three bytes at one per cycle while the
// receiver keeps up; a byte waits while the output register is still occupied. Once the
// queue is full, the input waits for the back end. A status result is emitted in its own
// state after any bytes of its command. Results leave through an output register and wait
// there until the receiver takes them.
module base64_line_decoder_unit #(
    parameter int unsigned LINE_CHARS   = 64,
    parameter int unsigned MAX_LINE_LEN = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  b64ld_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output b64ld_pkg::t_out_item  o_out_item
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    b64ld_pkg::t_cmd push_cmd;
    b64ld_pkg::t_cmd pop_cmd;

    b64ld_front #(
        .LINE_CHARS   (LINE_CHARS),
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    b64ld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (empty)
    );

    b64ld_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_cmd       (pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
